// ===== rtl/core/ppp_pkg.sv =====
// Package for projected point pick: shared types, constants, and controller command/status.
package ppp_pkg;

  localparam int unsigned MaxPointsDefault  = 65536;
  localparam int unsigned MatrixFracDefault = 12;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned IdxW    = 17;
  localparam int unsigned DivW    = 50;
  localparam int unsigned QW      = 16;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWindow = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSum,
    StDiv,
    StDecide,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic sum;
    logic div_start;
    logic decide;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic keep;
  } status_t;

endpackage

// ===== rtl/core/ppp_ctrl.sv =====
// Controller for projected point pick: sequences load, multiply, sum, divide, decide, report.
module ppp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              counted_i,
  input  logic              last_i,
  input  ppp_pkg::status_t  status_i,
  output ppp_pkg::cmd_t     cmd_o
);

  ppp_pkg::state_e state_q, state_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppp_pkg::StIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_q)
      ppp_pkg::StIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          last_d = last_i;
          if (counted_i) state_d = ppp_pkg::StMul;
          else if (last_i) state_d = ppp_pkg::StOut;
        end
      end
      ppp_pkg::StMul: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_done) state_d = ppp_pkg::StSum;
      end
      ppp_pkg::StSum: begin
        cmd_o.sum = 1'b1;
        state_d = ppp_pkg::StDiv;
      end
      ppp_pkg::StDiv: begin
        if (!status_i.keep) begin
          state_d = ppp_pkg::StDecide;
        end else begin
          cmd_o.div_start = 1'b1;
          if (status_i.div_done) state_d = ppp_pkg::StDecide;
        end
      end
      ppp_pkg::StDecide: begin
        cmd_o.decide = 1'b1;
        state_d = last_q ? ppp_pkg::StOut : ppp_pkg::StIdle;
      end
      ppp_pkg::StOut: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd_o.clear = 1'b1;
          state_d = ppp_pkg::StIdle;
        end
      end
      default: state_d = ppp_pkg::StIdle;
    endcase
  end

endmodule

// ===== rtl/core/ppp_div.sv =====
// Restoring serial divider for projected point pick: signed quotient, truncated toward zero.
module ppp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ppp_pkg::DivW-1:0]  num_i,
  input  logic        [ppp_pkg::DivW-1:0]  den_i,
  output logic                             done_o,
  output logic signed [ppp_pkg::QW-1:0]    quo_o
);

  localparam int unsigned QBits = 15;
  localparam int unsigned CntW  = 4;

  logic [ppp_pkg::DivW-1:0] den_q, den_d, rem_q, rem_d;
  logic [QBits-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [ppp_pkg::DivW:0] trial;
  logic [ppp_pkg::DivW-1:0] rem_new;
  logic [ppp_pkg::QW-1:0] qext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // |num| <= den, quotient magnitude <= 2^14, one bit per cycle from 2^14 down
  always_comb begin
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    trial   = {1'b0, rem_q} - {1'b0, den_q};
    rem_new = rem_q;
    if (start_i && !busy_q && !done_q) begin
      neg_d  = num_i[ppp_pkg::DivW-1];
      rem_d  = num_i[ppp_pkg::DivW-1] ? ppp_pkg::DivW'(-num_i) : ppp_pkg::DivW'(num_i);
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = CntW'(QBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[ppp_pkg::DivW]) rem_new = trial[ppp_pkg::DivW-1:0];
      rem_d = rem_new << 1;
      quo_d = {quo_q[QBits-2:0], !trial[ppp_pkg::DivW]};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign qext   = {1'b0, quo_q};
  assign quo_o  = neg_q ? ppp_pkg::QW'(-qext) : qext;
  assign done_o = done_q;

endmodule

// ===== rtl/core/ppp_datapath.sv =====
// Datapath for projected point pick: config, serial MAC, frustum test, divide, window and best.
module ppp_datapath #(
  parameter int unsigned MAX_POINTS  = ppp_pkg::MaxPointsDefault,
  parameter int unsigned MATRIX_FRAC = ppp_pkg::MatrixFracDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ppp_pkg::CfgW-1:0]            cfg_data_i,
  input  logic signed [ppp_pkg::CoordW-1:0]   x_i,
  input  logic signed [ppp_pkg::CoordW-1:0]   y_i,
  input  logic signed [ppp_pkg::CoordW-1:0]   z_i,
  input  ppp_pkg::cmd_t                       cmd_i,
  output ppp_pkg::status_t                    status_o,
  output logic                                found_o,
  output logic signed [ppp_pkg::IdxW-1:0]     index_o
);

  localparam int unsigned CntW = $clog2(MAX_POINTS);
  localparam int unsigned AccW = ppp_pkg::DivW;

  logic [ppp_pkg::CfgW-1:0] row_q [4];
  logic [ppp_pkg::CfgW-1:0] win_q;
  logic signed [ppp_pkg::CoordW-1:0] p_q [3];
  logic [4:0] step_q, step_d;
  logic signed [AccW-1:0] acc_q [4];
  logic signed [AccW-1:0] prod_q;
  logic [1:0] prow_q, pcol_q;
  logic pvalid_q;
  logic issue;
  logic signed [15:0] m_e;
  logic signed [ppp_pkg::CoordW-1:0] p_e;
  logic keep_q;
  logic [1:0] axis_q;
  logic signed [15:0] n_q [3];
  logic div_done;
  logic signed [15:0] quo;
  logic [CntW-1:0] cnt_q;
  logic signed [15:0] best_d_q;
  logic [CntW-1:0] best_i_q;
  logic best_v_q;
  logic signed [17:0] lox, hix, loy, hiy;
  logic cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        row_q[r] <= ppp_pkg::CfgW'(64'd1 << (MATRIX_FRAC + 16 * r));
      end
      win_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppp_pkg::RegRow0:   row_q[0] <= cfg_data_i;
        ppp_pkg::RegRow1:   row_q[1] <= cfg_data_i;
        ppp_pkg::RegRow2:   row_q[2] <= cfg_data_i;
        ppp_pkg::RegRow3:   row_q[3] <= cfg_data_i;
        ppp_pkg::RegWindow: win_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one 16x32 product per cycle, 16 steps, each accumulated in the cycle after its product
  assign m_e = row_q[step_q[3:2]][16*step_q[1:0] +: 16];
  always_comb begin
    case (step_q[1:0])
      2'd0: p_e = p_q[0];
      2'd1: p_e = p_q[1];
      2'd2: p_e = p_q[2];
      default: p_e = 32'sd256;
    endcase
  end

  assign issue = cmd_i.mul_step && !step_q[4];

  always_comb begin
    step_d = step_q;
    if (cmd_i.load) step_d = '0;
    else if (issue) step_d = step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      pvalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      pvalid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q[0] <= x_i;
      p_q[1] <= y_i;
      p_q[2] <= z_i;
      for (int r = 0; r < 4; r++) acc_q[r] <= '0;
    end else if (pvalid_q) begin
      acc_q[prow_q] <= acc_q[prow_q] + prod_q;
    end
    prod_q <= AccW'(m_e * p_e);
    prow_q <= step_q[3:2];
    pcol_q <= step_q[1:0];
  end

  assign status_o.mul_done = pvalid_q && prow_q == 2'd3 && pcol_q == 2'd3;

  // frustum test
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      keep_q <= acc_q[3] > 0 &&
                -acc_q[3] <= acc_q[0] && acc_q[0] <= acc_q[3] &&
                -acc_q[3] <= acc_q[1] && acc_q[1] <= acc_q[3] &&
                -acc_q[3] <= acc_q[2] && acc_q[2] <= acc_q[3];
    end
  end
  assign status_o.keep = keep_q;

  ppp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start && axis_q != 2'd3),
    .num_i   (acc_q[axis_q]),
    .den_i   (acc_q[3]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) axis_q <= '0;
    else if (cmd_i.sum) axis_q <= '0;
    else if (div_done) axis_q <= axis_q + 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (div_done) n_q[axis_q] <= quo;
  end
  assign status_o.div_done = div_done && axis_q == 2'd2;

  always_comb begin
    lox = 18'(signed'(win_q[15:0])) - 18'(signed'(win_q[47:32]));
    hix = 18'(signed'(win_q[15:0])) + 18'(signed'(win_q[47:32]));
    loy = 18'(signed'(win_q[31:16])) - 18'(signed'(win_q[63:48]));
    hiy = 18'(signed'(win_q[31:16])) + 18'(signed'(win_q[63:48]));
    cand = keep_q &&
           lox <= 18'(n_q[0]) && 18'(n_q[0]) <= hix &&
           loy <= 18'(n_q[1]) && 18'(n_q[1]) <= hiy &&
           n_q[2] < best_d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      best_d_q <= ppp_pkg::OneQ14;
      best_i_q <= '0;
      best_v_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q    <= '0;
      best_d_q <= ppp_pkg::OneQ14;
      best_i_q <= '0;
      best_v_q <= 1'b0;
    end else if (cmd_i.decide) begin
      if (cand) begin
        best_d_q <= n_q[2];
        best_i_q <= cnt_q;
        best_v_q <= 1'b1;
      end
      if (cnt_q != CntW'(MAX_POINTS - 1)) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign found_o = best_v_q;
  assign index_o = best_v_q ? ppp_pkg::IdxW'(best_i_q) : '1;

endmodule

// ===== rtl/core/projected_point_pick.sv =====
// Top level of projected point pick: ports, controller and datapath.
// A counted point is accepted, then runs through the shared 16x32 multiply-accumulate (16
// products, then a drain of the last product), the frustum test, three divisions by w on
// the serial divider, and the window/depth update; a point outside the frustum skips the
// divisions. An uncounted point is only accepted. A point marked last is then followed by
// presenting found/landmark_index, held while stalled. Configuration may be written
// whenever no point is in flight.
module projected_point_pick #(
  parameter int unsigned MAX_POINTS  = ppp_pkg::MaxPointsDefault,
  parameter int unsigned MATRIX_FRAC = ppp_pkg::MatrixFracDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ppp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ppp_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ppp_pkg::CoordW-1:0] x_coord_i,
  input  logic signed [ppp_pkg::CoordW-1:0] y_coord_i,
  input  logic signed [ppp_pkg::CoordW-1:0] z_coord_i,
  input  logic                              counted_i,
  input  logic                              last_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found_o,
  output logic signed [ppp_pkg::IdxW-1:0]   landmark_index_o
);

  ppp_pkg::cmd_t    cmd;
  ppp_pkg::status_t status;

  ppp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .counted_i (counted_i),
    .last_i    (last_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ppp_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .MATRIX_FRAC (MATRIX_FRAC)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .x_i        (x_coord_i),
    .y_i        (y_coord_i),
    .z_i        (z_coord_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .found_o    (found_o),
    .index_o    (landmark_index_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for projected_point_pick: directed table, then randomized pick runs.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MaxPts   = 64;
  localparam int          StallLim = 20000;
  localparam int          HoldLen  = 400;
  localparam logic [ppp_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  typedef enum logic { RowPoint, RowCfg } row_kind_e;

  typedef struct packed {
    logic        found;
    logic [16:0] idx;
  } pick_res_t;

  typedef struct {
    row_kind_e                     kind;
    logic [ppp_pkg::CfgIdxW-1:0]   reg_idx;
    logic [ppp_pkg::CfgW-1:0]      data;
    logic signed [31:0]            x;
    logic signed [31:0]            y;
    logic signed [31:0]            z;
    bit                            cnt;
    bit                            lst;
    bit                            typed;
    pick_res_t                     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [ppp_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [ppp_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] x_coord = '0, y_coord = '0, z_coord = '0;
  logic counted = 1'b0, last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic signed [ppp_pkg::IdxW-1:0] landmark_index;

  always #2 clk = ~clk;

  projected_point_pick #(
    .MAX_POINTS(MaxPts), .MATRIX_FRAC(ppp_pkg::MatrixFracDefault)
  ) DUT (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_coord_i(x_coord), .y_coord_i(y_coord), .z_coord_i(z_coord),
    .counted_i(counted), .last_i(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .found_o(found), .landmark_index_o(landmark_index)
  );

  // predictor state
  logic [ppp_pkg::CfgW-1:0] mat_row [4];
  logic [ppp_pkg::CfgW-1:0] win_reg;
  int unsigned     pt_count;
  longint          best_depth;
  int              best_idx;

  pick_res_t expected_picks [$];
  int  mismatches = 0;
  int  picks_seen = 0;
  int  points_sent = 0;
  int  found_hits = 0;
  bit  quiet_rx = 1'b0;
  bit  hold_req = 1'b0;

  function automatic logic [63:0] pack4(input int e0, input int e1, input int e2, input int e3);
    pack4 = {e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
  endfunction

  function automatic longint field16(input logic [63:0] w, input int k);
    logic signed [15:0] v;
    v = w[16*k +: 16];
    field16 = longint'(v);
  endfunction

  function automatic void clear_pick();
    pt_count = 0;
    best_depth = 16384;
    best_idx = -1;
  endfunction

  function automatic void apply_cfg(input logic [ppp_pkg::CfgIdxW-1:0] i, input logic [63:0] d);
    if (i <= ppp_pkg::RegRow3) mat_row[i[1:0]] = d;
    else if (i == ppp_pkg::RegWindow) win_reg = d;
  endfunction

  function automatic bit pick_step(input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic signed [31:0] z, input bit cnt, input bit lst,
                                   output pick_res_t res);
    longint p [4];
    longint c [4];
    longint nx, ny, nz, cx, cy, tx, ty;
    p[0] = longint'(x); p[1] = longint'(y); p[2] = longint'(z); p[3] = 256;
    if (cnt) begin
      for (int r = 0; r < 4; r++) begin
        c[r] = 0;
        for (int k = 0; k < 4; k++) c[r] += field16(mat_row[r], k) * p[k];
      end
      if (c[3] > 0 && -c[3] <= c[0] && c[0] <= c[3] && -c[3] <= c[1] && c[1] <= c[3] &&
          -c[3] <= c[2] && c[2] <= c[3]) begin
        nx = (c[0] * 16384) / c[3];
        ny = (c[1] * 16384) / c[3];
        nz = (c[2] * 16384) / c[3];
        cx = field16(win_reg, 0); cy = field16(win_reg, 1);
        tx = field16(win_reg, 2); ty = field16(win_reg, 3);
        if (cx - tx <= nx && nx <= cx + tx && cy - ty <= ny && ny <= cy + ty &&
            nz < best_depth) begin
          best_depth = nz;
          best_idx = int'(pt_count);
        end
      end
      if (pt_count < MaxPts - 1) pt_count++;
    end
    if (!lst) return 1'b0;
    res.found = (best_idx >= 0);
    res.idx = (best_idx >= 0) ? best_idx[16:0] : 17'h1FFFF;
    clear_pick();
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_idle();
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [ppp_pkg::CfgIdxW-1:0] i, input logic [63:0] d);
    @(negedge clk);
    cfg_we = 1'b1; cfg_idx = i; cfg_data = d;
    @(posedge clk);
    apply_cfg(i, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input bit cnt, input bit lst,
                            input bit typed, input pick_res_t typed_res, input bit gaps);
    pick_res_t res;
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    x_coord = x; y_coord = y; z_coord = z; counted = cnt; last = lst;
    do @(posedge clk); while (in_stall);
    points_sent++;
    if (pick_step(x, y, z, cnt, lst, res)) expected_picks.push_back(typed ? typed_res : res);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $signed($urandom_range(0, 600)) - 300;
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd256;
      default: return -32'sd256;
    endcase
  endfunction

  function automatic int rand_ent(input int lo, input int hi);
    return $signed($urandom_range(0, hi - lo)) + lo;
  endfunction

  task automatic setup_phase(input int ph);
    int d;
    case (ph % 8)
      0: begin
        for (int r = 0; r < 4; r++)
          write_cfg(ppp_pkg::CfgIdxW'(r), 64'(4096) << (16 * r));
        write_cfg(ppp_pkg::RegWindow, pack4(0, 0, 4096, 4096));
      end
      1: write_cfg(ppp_pkg::RegWindow, pack4(rand_ent(-8000, 8000), rand_ent(-8000, 8000),
                                             rand_ent(0, 8000), rand_ent(0, 8000)));
      2: begin
        d = rand_ent(2048, 8191);
        write_cfg(ppp_pkg::RegRow0, pack4(rand_ent(2048, 8191), 0, 0, rand_ent(-64, 64)));
        write_cfg(ppp_pkg::RegRow1, pack4(0, rand_ent(2048, 8191), 0, rand_ent(-64, 64)));
        write_cfg(ppp_pkg::RegRow2, pack4(0, 0, rand_ent(2048, 8191), rand_ent(-64, 64)));
        write_cfg(ppp_pkg::RegRow3, pack4(0, 0, 0, d));
        write_cfg(ppp_pkg::RegWindow, pack4(rand_ent(-2000, 2000), rand_ent(-2000, 2000),
                                            rand_ent(2000, 16000), rand_ent(2000, 16000)));
      end
      3: for (int r = 0; r < 4; r++)
        write_cfg(ppp_pkg::CfgIdxW'(r),
                  pack4(rand_ent(-512, 512) + (r == 0 ? 4096 : 0),
                        rand_ent(-512, 512) + (r == 1 ? 4096 : 0),
                        rand_ent(-512, 512) + (r == 2 ? 4096 : 0),
                        rand_ent(-512, 512) + (r == 3 ? 4096 : 0)));
      4: begin
        write_cfg(ppp_pkg::RegRow0, pack4(32767, -32768, 0, 0));
        write_cfg(ppp_pkg::RegRow1, pack4(-32768, 32767, 0, 0));
        write_cfg(ppp_pkg::RegRow2, pack4(0, 0, -32768, 0));
        write_cfg(ppp_pkg::RegRow3, pack4(32767, 32767, 32767, 32767));
        write_cfg(ppp_pkg::RegWindow, pack4(0, 0, 32767, 32767));
      end
      5: begin
        for (int r = 0; r < 4; r++)
          write_cfg(ppp_pkg::CfgIdxW'(r), 64'(4096) << (16 * r));
        write_cfg(ppp_pkg::RegWindow, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      6: write_cfg(ppp_pkg::RegWindow, pack4(-32768, 32767, 32767, 32767));
      default: begin
        for (int r = 0; r < 4; r++) write_cfg(ppp_pkg::CfgIdxW'(r), {$urandom, $urandom});
        write_cfg(ppp_pkg::RegWindow, {$urandom, $urandom});
      end
    endcase
  endtask

  // result side: random stall (none while quiet_rx), one long hold-off on request
  int stall_left = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HoldLen) begin
      out_stall = 1'b1;
      hold_cnt++;
    end else if (quiet_rx) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      stall_left = gap_len();
      out_stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    pick_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      picks_seen++;
      if (found) found_hits++;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pick: found=%0b idx=%0d", found, landmark_index);
      end else begin
        want = expected_picks.pop_front();
        if (found !== want.found || landmark_index !== want.idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pick %0d: expected found=%0b idx=%0d, got found=%0b idx=%0d", picks_seen,
                     want.found, $signed(want.idx), found, landmark_index);
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLim) begin
      $display("Some tests failed");
      $finish;
    end
  end

  stim_row_t directed [$];

  function automatic stim_row_t pt(input int x, input int y, input int z, input bit c,
                                   input bit l, input bit t, input bit f, input int i);
    stim_row_t s;
    s.kind = RowPoint; s.reg_idx = '0; s.data = '0;
    s.x = x; s.y = y; s.z = z; s.cnt = c; s.lst = l; s.typed = t;
    s.res.found = f; s.res.idx = i[16:0];
    return s;
  endfunction

  function automatic stim_row_t cf(input logic [ppp_pkg::CfgIdxW-1:0] i, input logic [63:0] d);
    stim_row_t s;
    s = pt(0, 0, 0, 0, 0, 0, 0, 0);
    s.kind = RowCfg; s.reg_idx = i; s.data = d;
    return s;
  endfunction

  initial begin
    int n, len;
    for (int r = 0; r < 4; r++)
      mat_row[r] = 64'(1 << ppp_pkg::MatrixFracDefault) << (16 * r);
    win_reg = '0;
    clear_pick();

    directed.push_back(pt(0, 0, 0, 0, 1, 1, 0, -1));
    directed.push_back(pt(0, 0, 0, 1, 1, 1, 1, 0));
    directed.push_back(pt(0, 0, 256, 1, 1, 1, 0, -1));
    directed.push_back(pt(0, 0, -256, 1, 1, 1, 1, 0));
    directed.push_back(pt(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 1, 0, -1));
    directed.push_back(pt(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1, 0, -1));
    directed.push_back(pt(1, 0, 0, 1, 1, 1, 0, -1));
    directed.push_back(pt(0, 0, 100, 1, 0, 0, 0, 0));
    directed.push_back(pt(0, 0, 50, 1, 0, 0, 0, 0));
    directed.push_back(pt(0, 0, 50, 1, 0, 0, 0, 0));
    directed.push_back(pt(0, 0, -200, 0, 0, 0, 0, 0));
    directed.push_back(pt(0, 0, 200, 1, 1, 1, 1, 1));
    directed.push_back(pt(257, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(pt(0, 0, -100, 1, 1, 1, 1, 1));
    directed.push_back(cf(ppp_pkg::RegRow3, 64'h0));
    directed.push_back(pt(0, 0, 0, 1, 1, 1, 0, -1));
    directed.push_back(cf(ppp_pkg::RegRow3, pack4(0, 0, 0, -4096)));
    directed.push_back(pt(0, 0, 0, 1, 1, 1, 0, -1));
    directed.push_back(cf(ppp_pkg::RegRow3, pack4(0, 0, 0, 4096)));
    directed.push_back(cf(ppp_pkg::RegWindow, pack4(0, 0, -1, -1)));
    directed.push_back(pt(0, 0, 0, 1, 1, 1, 0, -1));
    directed.push_back(cf(ppp_pkg::RegWindow, 64'h0));
    directed.push_back(cf(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(pt(0, 0, 0, 1, 1, 1, 1, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == RowCfg) begin
        @(negedge clk);
        in_valid = 1'b0;
        wait_idle();
        write_cfg(directed[i].reg_idx, directed[i].data);
      end else begin
        send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].cnt,
                   directed[i].lst, directed[i].typed, directed[i].res, 1'b1);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      @(negedge clk);
      in_valid = 1'b0;
      wait_idle();
      setup_phase(ph);
      quiet_rx = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      n = 0;
      while (n < 62) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxPts, MaxPts + 16)
                                          : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 9) != 0,
                     (k == len - 1) || ($urandom_range(0, 39) == 0), 1'b0, '0, ph != 3);
          n++;
        end
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    quiet_rx = 1'b0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d points over 8 matrix/window settings; %0d picks checked, %0d found.",
             points_sent, picks_seen, found_hits);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ppp_pkg.sv
rtl/core/ppp_ctrl.sv
rtl/core/ppp_div.sv
rtl/core/ppp_datapath.sv
rtl/core/projected_point_pick.sv
tb/tb_top.sv
